// ----- src/frl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_pkg
// Shared widths, codes and the flow table entry for the per-flow rate limiter.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned BYTES_W  = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned CREDIT_W = 48;
  localparam int unsigned BKT_W    = 2;

  // rate * elapsed, then divided by one thousand
  localparam int unsigned PROD_W  = RATE_W + TIME_W;
  localparam int unsigned KQ_W    = 55;
  localparam int unsigned ALLOW_W = KQ_W + 1;

  localparam int unsigned MSK_W = 10;
  localparam logic [MSK_W-1:0] MS_PER_S = 10'd1000;

  // constant divider: quotient bits resolved per cycle
  localparam int unsigned KD_STEPS  = 8;
  localparam int unsigned KD_ROUNDS = PROD_W / KD_STEPS;
  localparam int unsigned KCNT_W    = $clog2(KD_ROUNDS);

  // deficit * 1000 / rate
  localparam int unsigned DVD_W  = BYTES_W + MSK_W;
  localparam int unsigned DCNT_W = $clog2(DVD_W);

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  localparam logic CFG_GLOBAL_LIMIT   = 1'b0;
  localparam logic CFG_PER_FLOW_LIMIT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_SEND  = 2'd2
  } cmd_e;

  typedef enum logic [BKT_W-1:0] {
    BKT_NONE   = 2'd0,
    BKT_FLOW   = 2'd1,
    BKT_GLOBAL = 2'd2
  } bucket_e;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [CREDIT_W-1:0] credit;
    logic [TIME_W-1:0]   stamp;
  } flow_ent_t;

endpackage

// ----- src/frl_kdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_kdiv
// Divides the credit product by one thousand, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module frl_kdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [frl_pkg::PROD_W-1:0] dividend_i,
  output logic                       done_o,
  output logic [frl_pkg::KQ_W-1:0]   quotient_o
);
  import frl_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [KCNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]   work_q;
  logic [PROD_W-1:0]   work_d;
  logic [MSK_W-1:0]    rem_q;
  logic [MSK_W-1:0]    rem_d;
  logic [KD_STEPS-1:0] qbits;
  logic [MSK_W:0]      trial;
  logic [MSK_W:0]      trial_sub;

  // remainder stays below 1000, so each step is a narrow compare
  always_comb begin
    rem_d     = rem_q;
    qbits     = '0;
    trial     = '0;
    trial_sub = '0;
    for (int i = 0; i < KD_STEPS; i++) begin
      trial     = {rem_d, work_q[PROD_W-1-i]};
      trial_sub = trial - {1'b0, MS_PER_S};
      if (trial >= {1'b0, MS_PER_S}) begin
        rem_d                 = trial_sub[MSK_W-1:0];
        qbits[KD_STEPS-1-i]   = 1'b1;
      end else begin
        rem_d = trial[MSK_W-1:0];
      end
    end
    work_d = {work_q[PROD_W-KD_STEPS-1:0], qbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + KCNT_W'(1);
        if (cnt_q == KCNT_W'(KD_ROUNDS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q[KQ_W-1:0];

endmodule

// ----- src/frl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_div
// Restoring divider for the delay, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [frl_pkg::DVD_W-1:0]  dividend_i,
  input  logic [frl_pkg::RATE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [frl_pkg::DVD_W-1:0]  quotient_o
);
  import frl_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]  work_q;
  logic [RATE_W-1:0] divisor_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   trial_sub;
  logic              qbit;

  assign trial     = {rem_q, work_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign qbit      = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q    <= dividend_i;
      divisor_q <= divisor_i;
      rem_q     <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[DVD_W-2:0], qbit};
      rem_q  <= qbit ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// ----- src/per_flow_rate_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_rate_limiter
// Token bucket byte-rate shaper over a table of flows plus one global bucket.
// ----------------------------------------------------------------------------
// Items are handled one at a time. After reset the block walks every entry of
// the flow valid table to clear it and takes no beat in that time. An open, a
// close, or a send report that is ignored goes from accept through LOOK to
// DONE and then to the result. A send report charged to a bucket reads the
// flow entry, forms rate * elapsed in one multiply, divides it by 1000 (8
// quotient bits a cycle) and settles the credit when the credit covers the
// bytes. On a shortfall the delay comes from a 42-step bit-serial divider.
// The next beat is taken as soon as the result sits in the output register,
// so a slow consumer costs no time until the following result is ready.
// ----------------------------------------------------------------------------
module per_flow_rate_limiter #(
  parameter int unsigned FLOW_COUNT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [frl_pkg::RATE_W-1:0]  cfg_data_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [frl_pkg::CMD_W-1:0]   cmd_i,
  input  logic [frl_pkg::ID_W-1:0]    flow_id_i,
  input  logic [frl_pkg::BYTES_W-1:0] byte_count_i,
  input  logic [frl_pkg::TIME_W-1:0]  now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [frl_pkg::TIME_W-1:0]  delay_ms_o,
  output logic [frl_pkg::BKT_W-1:0]   bucket_used_o
);
  import frl_pkg::*;

  localparam int unsigned IDX_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int unsigned EXT_W = IDX_W + ID_W;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_LOOK   = 10'b0000000100,
    ST_MUL    = 10'b0000001000,
    ST_KSTART = 10'b0000010000,
    ST_KWAIT  = 10'b0000100000,
    ST_CHECK  = 10'b0001000000,
    ST_DSTART = 10'b0010000000,
    ST_DWAIT  = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [RATE_W-1:0] global_limit_q;
  logic [RATE_W-1:0] per_flow_limit_q;

  // flow table
  logic      valid_mem_q [FLOW_COUNT];
  flow_ent_t flow_mem_q  [FLOW_COUNT];
  logic      rd_valid_q;
  flow_ent_t rd_ent_q;
  logic [IDX_W-1:0] clr_q;

  // global bucket
  logic [CREDIT_W-1:0] gcredit_q;
  logic [TIME_W-1:0]   gstamp_q;

  // item in flight
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic                inr_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic [TIME_W-1:0]   now_q;
  logic [RATE_W-1:0]   rate_q;
  logic [CREDIT_W-1:0] credit_q;
  logic [TIME_W-1:0]   stamp_q;
  logic [TIME_W-1:0]   diff_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ALLOW_W-1:0]  allow_q;
  logic [BYTES_W-1:0]  deficit_q;
  logic [TIME_W-1:0]   delay_q;
  bucket_e             use_q;
  logic                wrd_q;
  logic                wrg_q;
  logic                wrv_q;
  logic                vbit_q;

  // output register
  logic                out_valid_q;
  logic [TIME_W-1:0]   out_delay_q;
  logic [BKT_W-1:0]    out_bucket_q;

  logic [EXT_W-1:0]    in_id_ext;
  logic [IDX_W-1:0]    in_idx;
  logic                in_range;
  logic                accept;
  logic                fire;
  logic                clearing;

  logic                sel_flow;
  logic                send_ok;
  logic [RATE_W-1:0]   sel_rate;
  logic [CREDIT_W-1:0] sel_credit;
  logic [TIME_W-1:0]   sel_stamp;
  logic [TIME_W-1:0]   sel_diff;

  logic [ALLOW_W-1:0]  bytes_ext;
  logic [ALLOW_W-1:0]  left;
  logic [ALLOW_W-1:0]  short;
  logic                covered;

  logic                k_start;
  logic                k_done;
  logic [KQ_W-1:0]     k_quot;
  logic                d_start;
  logic                d_done;
  logic [DVD_W-1:0]    d_quot;
  logic [DVD_W-1:0]    d_dividend;

  logic                vwe;
  logic [IDX_W-1:0]    vaddr;
  logic                vdata;
  flow_ent_t           wr_ent;
  logic [TIME_W-1:0]   new_stamp;

  assign in_id_ext = {{IDX_W{1'b0}}, flow_id_i};
  assign in_idx    = in_id_ext[IDX_W-1:0];
  assign in_range  = (in_id_ext < EXT_W'(FLOW_COUNT));

  assign ready_o  = (state_q == ST_IDLE);
  assign accept   = valid_i && ready_o;
  assign clearing = (state_q == ST_CLEAR);
  assign fire     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // bucket choice: own rate first, then the shared one
  assign sel_flow   = (rd_ent_q.rate != '0);
  assign send_ok    = (cmd_q == CMD_SEND) && (bytes_q != '0) && inr_q && rd_valid_q &&
                      (sel_flow || (global_limit_q != '0));
  assign sel_rate   = sel_flow ? rd_ent_q.rate : global_limit_q;
  assign sel_credit = sel_flow ? rd_ent_q.credit : gcredit_q;
  assign sel_stamp  = sel_flow ? rd_ent_q.stamp : gstamp_q;
  assign sel_diff   = now_q - sel_stamp;

  assign bytes_ext = ALLOW_W'(bytes_q);
  assign left      = allow_q - bytes_ext;
  assign short     = bytes_ext - allow_q;
  assign covered   = (bytes_ext <= allow_q);

  assign k_start    = (state_q == ST_KSTART);
  assign d_start    = (state_q == ST_DSTART);
  assign d_dividend = DVD_W'(deficit_q) * DVD_W'(MS_PER_S);

  assign new_stamp = stamp_q + delay_q;
  assign wr_ent    = '{rate: rate_q, credit: credit_q, stamp: new_stamp};

  frl_kdiv u_frl_kdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (k_start),
    .dividend_i (prod_q),
    .done_o     (k_done),
    .quotient_o (k_quot)
  );

  frl_div u_frl_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (d_start),
    .dividend_i (d_dividend),
    .divisor_i  (rate_q),
    .done_o     (d_done),
    .quotient_o (d_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(FLOW_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (send_ok && !sel_diff[TIME_W-1]) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL:    state_d = ST_KSTART;
      ST_KSTART: state_d = ST_KWAIT;
      ST_KWAIT: begin
        if (k_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = covered ? ST_DONE : ST_DSTART;
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (d_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_limit_q   <= '0;
      per_flow_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GLOBAL_LIMIT:   global_limit_q   <= cfg_data_i;
        CFG_PER_FLOW_LIMIT: per_flow_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid table: clearing pass after reset, then open and close
  assign vwe   = clearing || (fire && wrv_q);
  assign vaddr = clearing ? clr_q : idx_q;
  assign vdata = !clearing && vbit_q;

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      valid_mem_q[vaddr] <= vdata;
    end
    if (fire && wrd_q) begin
      flow_mem_q[idx_q] <= wr_ent;
    end
    if (accept) begin
      rd_valid_q <= valid_mem_q[in_idx];
      rd_ent_q   <= flow_mem_q[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcredit_q <= '0;
      gstamp_q  <= '0;
    end else if (fire && wrg_q) begin
      gcredit_q <= credit_q;
      gstamp_q  <= new_stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q   <= cmd_i;
        idx_q   <= in_idx;
        inr_q   <= in_range;
        bytes_q <= byte_count_i;
        now_q   <= now_ms_i;
      end
      ST_LOOK: begin
        wrd_q   <= 1'b0;
        wrg_q   <= 1'b0;
        wrv_q   <= 1'b0;
        vbit_q  <= 1'b0;
        use_q   <= BKT_NONE;
        delay_q <= '0;
        stamp_q <= now_q;
        case (cmd_q)
          CMD_OPEN: begin
            if (inr_q) begin
              wrv_q    <= 1'b1;
              vbit_q   <= 1'b1;
              wrd_q    <= 1'b1;
              rate_q   <= per_flow_limit_q;
              credit_q <= '0;
            end
          end
          CMD_CLOSE: begin
            wrv_q <= inr_q;
          end
          CMD_SEND: begin
            // a stamp ahead of now means the report is ignored
            if (send_ok && !sel_diff[TIME_W-1]) begin
              use_q    <= sel_flow ? BKT_FLOW : BKT_GLOBAL;
              wrd_q    <= sel_flow;
              wrg_q    <= !sel_flow;
              rate_q   <= sel_rate;
              credit_q <= sel_credit;
              diff_q   <= sel_diff;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        prod_q <= PROD_W'(rate_q) * PROD_W'(diff_q);
      end
      ST_KWAIT: begin
        if (k_done) begin
          allow_q <= ALLOW_W'(credit_q) + ALLOW_W'(k_quot);
        end
      end
      ST_CHECK: begin
        if (covered) begin
          credit_q <= (left > ALLOW_W'(CREDIT_MAX)) ? CREDIT_MAX : left[CREDIT_W-1:0];
        end else begin
          credit_q  <= '0;
          deficit_q <= short[BYTES_W-1:0];
        end
      end
      ST_DWAIT: begin
        if (d_done) begin
          delay_q <= (d_quot[DVD_W-1:TIME_W] != '0) ? '1 : d_quot[TIME_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_delay_q  <= delay_q;
      out_bucket_q <= use_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign delay_ms_o    = out_delay_q;
  assign bucket_used_o = out_bucket_q;

endmodule

// ----- src/frl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_checker
// Port-level checks for the per-flow rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module frl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        valid_i,
  input logic                        ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [frl_pkg::TIME_W-1:0]  delay_ms_o,
  input logic [frl_pkg::BKT_W-1:0]   bucket_used_o
);
  import frl_pkg::*;

  // no bucket charged means no wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bucket_used_o == BKT_NONE) |-> (delay_ms_o == '0))
    else $error("delay reported without a bucket");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(delay_ms_o) &&
                                    $stable(bucket_used_o))
    else $error("result beat changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !ready_o)
    else $error("input taken while an item is in flight");

  // no result can appear the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind per_flow_rate_limiter frl_checker u_frl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .ready_o       (ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .delay_ms_o    (delay_ms_o),
  .bucket_used_o (bucket_used_o)
);
